### rtl/lcgrd_pkg.sv
package lcgrd_pkg;

  // Generator constants
  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_ADD  = 32'd12345;
  localparam logic [30:0] LCG_MASK = 31'h7FFF_FFFF;
  localparam logic [31:0] SEED_RST = 32'd1;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned VALUE_W = 55;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned RAND_W  = 31;

  // Steps chained by a wide draw, and the bit shift between them
  localparam logic [1:0] WIDE_LAST  = 2'd3;
  localparam int unsigned WIDE_SHIFT = 8;

  // Request kinds; the fourth code is undefined and yields a zero result
  typedef enum logic [KIND_W-1:0] {
    KIND_RAW     = 2'd0,
    KIND_WIDE    = 2'd1,
    KIND_BOUNDED = 2'd2
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP_MUL,
    ST_STEP_ADD,
    ST_SCALE_MUL,
    ST_DIV_A,
    ST_DIV_B,
    ST_FINISH
  } state_e;

  // Operand pair for the shared multiplier
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

### rtl/lcgrd_req_if.sv
interface lcgrd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] upper_limit;

  modport source (output valid, output kind, output upper_limit, input ready);
  modport sink   (input valid, input kind, input upper_limit, output ready);
endinterface

### rtl/lcgrd_rsp_if.sv
interface lcgrd_rsp_if;
  logic        valid;
  logic        ready;
  logic [54:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

### rtl/lcgrd_mul.sv
module lcgrd_mul (
  input  logic                             clk_i,
  input  lcgrd_pkg::mul_req_t              req_i,
  output logic [lcgrd_pkg::PROD_W-1:0]     prod_o
);

  logic [lcgrd_pkg::PROD_W-1:0] prod_q;
  logic [lcgrd_pkg::PROD_W-1:0] prod_d;

  // Full 32x32 product, registered
  assign prod_d = {32'd0, req_i.a} * {32'd0, req_i.b};

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

### rtl/lcgrd_ctrl.sv
module lcgrd_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [31:0]                       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lcgrd_pkg::KIND_W-1:0]      kind_i,
  input  logic [lcgrd_pkg::LIMIT_W-1:0]     upper_limit_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lcgrd_pkg::VALUE_W-1:0]     value_o,
  output lcgrd_pkg::mul_req_t               mul_req_o,
  input  logic [lcgrd_pkg::PROD_W-1:0]      mul_prod_i
);

  lcgrd_pkg::state_e                  state_q, state_d;
  lcgrd_pkg::kind_e                   kind_q, kind_d;
  logic [31:0]                        gen_q, gen_d;
  logic [1:0]                         cnt_q, cnt_d;
  logic [lcgrd_pkg::LIMIT_W-1:0]      limit_q, limit_d;
  logic [lcgrd_pkg::VALUE_W-1:0]      acc_q, acc_d;
  logic [lcgrd_pkg::VALUE_W-1:0]      res_q, res_d;
  logic [31:0]                        quo_q, quo_d;
  logic [32:0]                        rem_q, rem_d;
  logic                               out_valid_q, out_valid_d;
  logic [lcgrd_pkg::VALUE_W-1:0]      value_q, value_d;

  logic [31:0]                        step_sum;
  logic [lcgrd_pkg::RAND_W-1:0]       rnd;
  logic [lcgrd_pkg::VALUE_W-1:0]      acc_next;
  logic [31:0]                        fold;
  logic                               fold_ge;
  logic                               in_fire;

  // Generator step tail: low word of product plus increment, top bit dropped
  assign step_sum = mul_prod_i[31:0] + lcgrd_pkg::LCG_ADD;
  assign rnd      = step_sum[lcgrd_pkg::RAND_W-1:0];
  assign acc_next = {acc_q[lcgrd_pkg::VALUE_W-1-lcgrd_pkg::WIDE_SHIFT:0],
                     lcgrd_pkg::WIDE_SHIFT'(0)}
                    ^ {24'd0, rnd};

  // Second fold of the division by 2^31-1 (2^31 is 1 modulo the divisor)
  assign fold    = {30'd0, rem_q[32:31]} + {1'b0, rem_q[30:0]};
  assign fold_ge = fold >= {1'b0, lcgrd_pkg::LCG_MASK};

  assign in_ready_o = (state_q == lcgrd_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Next state and datapath
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    gen_d       = gen_q;
    cnt_d       = cnt_q;
    limit_d     = limit_q;
    acc_d       = acc_q;
    res_d       = res_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    mul_req_o.a = gen_q;
    mul_req_o.b = lcgrd_pkg::LCG_MUL;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      lcgrd_pkg::ST_IDLE: begin
        if (cfg_we_i) begin
          gen_d = cfg_wdata_i;
        end
        if (in_fire) begin
          limit_d = upper_limit_i;
          cnt_d   = 2'd0;
          acc_d   = '0;
          case (kind_i)
            lcgrd_pkg::KIND_RAW,
            lcgrd_pkg::KIND_WIDE,
            lcgrd_pkg::KIND_BOUNDED: begin
              kind_d  = lcgrd_pkg::kind_e'(kind_i);
              state_d = lcgrd_pkg::ST_STEP_MUL;
            end
            default: begin
              res_d   = '0;
              state_d = lcgrd_pkg::ST_FINISH;
            end
          endcase
        end
      end

      lcgrd_pkg::ST_STEP_MUL: begin
        state_d = lcgrd_pkg::ST_STEP_ADD;
      end

      lcgrd_pkg::ST_STEP_ADD: begin
        gen_d = {1'b0, rnd};
        acc_d = acc_next;
        cnt_d = cnt_q + 2'd1;
        case (kind_q)
          lcgrd_pkg::KIND_WIDE: begin
            if (cnt_q == lcgrd_pkg::WIDE_LAST) begin
              res_d   = acc_next;
              state_d = lcgrd_pkg::ST_FINISH;
            end else begin
              state_d = lcgrd_pkg::ST_STEP_MUL;
            end
          end
          lcgrd_pkg::KIND_BOUNDED: begin
            state_d = lcgrd_pkg::ST_SCALE_MUL;
          end
          default: begin
            res_d   = {24'd0, rnd};
            state_d = lcgrd_pkg::ST_FINISH;
          end
        endcase
      end

      // limit * r on the shared multiplier
      lcgrd_pkg::ST_SCALE_MUL: begin
        mul_req_o.a = limit_q;
        mul_req_o.b = gen_q;
        state_d     = lcgrd_pkg::ST_DIV_A;
      end

      // First fold: high part is the quotient estimate, added back to low part
      lcgrd_pkg::ST_DIV_A: begin
        quo_d   = mul_prod_i[62:31];
        rem_d   = {1'b0, mul_prod_i[62:31]} + {2'd0, mul_prod_i[30:0]};
        state_d = lcgrd_pkg::ST_DIV_B;
      end

      // Second fold and final correction
      lcgrd_pkg::ST_DIV_B: begin
        res_d   = {23'd0, quo_q + {30'd0, rem_q[32:31]} + {31'd0, fold_ge}};
        state_d = lcgrd_pkg::ST_FINISH;
      end

      lcgrd_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          value_d     = res_q;
          state_d     = lcgrd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lcgrd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcgrd_pkg::ST_IDLE;
      gen_q       <= lcgrd_pkg::SEED_RST;
      out_valid_q <= 1'b0;
      cnt_q       <= 2'd0;
      kind_q      <= lcgrd_pkg::KIND_RAW;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      kind_q      <= kind_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    limit_q <= limit_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    value_q <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule

### rtl/lcg_random_draw_unit_top.sv
// Requests are taken only in the idle state, so one transaction is in flight at a
// time. Each generator step goes through the one shared multiplier, and a result
// not yet taken holds the sequencer until the output register frees.
// Reset (async, active low): idle, no result pending, generator state = 1.
module lcg_random_draw_unit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  lcgrd_req_if.sink   req_i,
  lcgrd_rsp_if.source rsp_o
);

  lcgrd_pkg::mul_req_t                mul_req;
  logic [lcgrd_pkg::PROD_W-1:0]       mul_prod;

  // Sequencer and generator state
  lcgrd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (req_i.valid),
    .in_ready_o    (req_i.ready),
    .kind_i        (req_i.kind),
    .upper_limit_i (req_i.upper_limit),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .value_o       (rsp_o.value),
    .mul_req_o     (mul_req),
    .mul_prod_i    (mul_prod)
  );

  // Shared multiplier
  lcgrd_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (mul_prod)
  );

endmodule
